// ===== design/cfb_pkg.sv =====
// ----------------------------------------------------------------------------
// cfb_pkg
// Shared types and constants of the connection flood ban table.
// ----------------------------------------------------------------------------
package cfb_pkg;

  localparam int AddrW    = 32;
  localparam int TimeW    = 40;
  localparam int LenW     = 32;
  localparam int WindowW  = 20;
  localparam int BurstW   = 6;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WINDOW_MS      = 3'd0,
    CFG_BURST_LIMIT    = 3'd1,
    CFG_RECENT_MS      = 3'd2,
    CFG_INITIAL_BAN_MS = 3'd3,
    CFG_BAN_MEMORY_MS  = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    VERD_ACCEPT = 2'd0,
    VERD_REJECT = 2'd1,
    VERD_BANNED = 2'd2,
    VERD_FULL   = 2'd3
  } verdict_e;

  typedef struct packed {
    logic [WindowW-1:0] window_ms;
    logic [BurstW-1:0]  burst_limit;
    logic [WindowW-1:0] recent_ms;
    logic [LenW-1:0]    initial_ban_ms;
    logic [LenW-1:0]    ban_memory_ms;
  } cfg_t;

  localparam logic [WindowW-1:0] WindowReset  = 20'd30000;
  localparam logic [BurstW-1:0]  BurstReset   = 6'd4;
  localparam logic [WindowW-1:0] RecentReset  = 20'd10000;
  localparam logic [LenW-1:0]    InitialReset = 32'd10000;
  localparam logic [LenW-1:0]    MemoryReset  = 32'd300000;

endpackage

// ===== design/connection_flood_ban_table.sv =====
// ----------------------------------------------------------------------------
// connection_flood_ban_table
// Rate limiter for connection attempts with escalating address bans.
// ----------------------------------------------------------------------------
// Each item on the s_axis channel is one connection attempt (address, time,
// slot flag in tuser); each produces exactly one verdict item on m_axis.
// Registers are written through the cfg channel; the user must write them
// only while the block is idle, which the block itself does not enforce. The
// connection log lives in one RAM of CONN_DEPTH entries; the ban list and the
// ban length records share a second RAM of 2*BAN_DEPTH entries. All three are
// circular lists kept oldest first and compacted in place as they are walked,
// one entry per cycle. An attempt that sets a ban also passes ST_BPUSH and
// ST_LUPD; a rejected attempt ends after the first two walks.
// One item is processed at a time; a new item is taken while the previous
// verdict still waits in the output register. A stalled receiver holds the
// verdict and, once the next item is done, stops the block.
// Reset empties all lists and restores the register defaults at once.
// ----------------------------------------------------------------------------
module connection_flood_ban_table #(
  parameter int CONN_DEPTH = 64,
  parameter int BAN_DEPTH  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // fields from bit 0: source_address[31:0], now_ms[71:32]
  input  logic [71:0]                  s_axis_tdata,
  // fields from bit 0: slot_free
  input  logic [0:0]                   s_axis_tuser,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // fields from bit 0: verdict[1:0], ban_length_ms[33:2], zero fill
  output logic [39:0]                  m_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [cfb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [cfb_pkg::CfgDataW-1:0] cfg_data_i
);
  import cfb_pkg::*;

  localparam int CIW = $clog2(CONN_DEPTH);
  localparam int CCW = $clog2(CONN_DEPTH + 1);
  localparam int BIW = $clog2(BAN_DEPTH);
  localparam int BCW = $clog2(BAN_DEPTH + 1);
  localparam int BAW = BIW + 1;
  localparam int MW  = (CCW > BurstW) ? CCW : BurstW;

  localparam logic [CIW:0]   CDepth  = (CIW + 1)'(CONN_DEPTH);
  localparam logic [BIW:0]   BDepth  = (BIW + 1)'(BAN_DEPTH);
  localparam logic [CCW-1:0] CFull   = CCW'(CONN_DEPTH);
  localparam logic [BCW-1:0] BFull   = BCW'(BAN_DEPTH);
  localparam logic [BAW-1:0] LenBase = BAW'(BAN_DEPTH);

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [TimeW-1:0] tm;
  } conn_ent_t;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [LenW-1:0]  ms;
    logic [TimeW-1:0] tm;
  } tab_ent_t;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b00000000001,
    ST_BSCAN  = 11'b00000000010,
    ST_LSCAN  = 11'b00000000100,
    ST_DECIDE = 11'b00000001000,
    ST_BCOMP  = 11'b00000010000,
    ST_LCOMP  = 11'b00000100000,
    ST_CCOMP  = 11'b00001000000,
    ST_CPUSH  = 11'b00010000000,
    ST_BPUSH  = 11'b00100000000,
    ST_LUPD   = 11'b01000000000,
    ST_DONE   = 11'b10000000000
  } state_e;

  function automatic logic [CIW-1:0] cphys(input logic [CIW-1:0] h, input logic [CIW-1:0] j);
    logic [CIW:0] s;
    s = {1'b0, h} + {1'b0, j};
    if (s >= CDepth) s = s - CDepth;
    return s[CIW-1:0];
  endfunction

  function automatic logic [BIW-1:0] bphys(input logic [BIW-1:0] h, input logic [BIW-1:0] j);
    logic [BIW:0] s;
    s = {1'b0, h} + {1'b0, j};
    if (s >= BDepth) s = s - BDepth;
    return s[BIW-1:0];
  endfunction

  function automatic logic [TimeW-1:0] age_of(input logic [TimeW-1:0] n,
                                               input logic [TimeW-1:0] t);
    return (n >= t) ? (n - t) : '0;
  endfunction

  function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] t,
                                                input logic [LenW-1:0]  d);
    logic [TimeW:0] s;
    s = {1'b0, t} + (TimeW + 1)'(d);
    return s[TimeW] ? '1 : s[TimeW-1:0];
  endfunction

  cfg_t cfg;

  cfb_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // RAM ports
  logic            c_we;
  logic [CIW-1:0]  c_waddr, c_raddr;
  conn_ent_t       c_wdata, c_rent;
  logic            b_we;
  logic [BAW-1:0]  b_waddr, b_raddr;
  tab_ent_t        b_wdata, b_rent;

  cfb_ram #(.Width($bits(conn_ent_t)), .Depth(CONN_DEPTH)) u_conn_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .raddr_i (c_raddr),
    .rdata_o (c_rent)
  );

  cfb_ram #(.Width($bits(tab_ent_t)), .Depth(2 * BAN_DEPTH)) u_ban_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .raddr_i (b_raddr),
    .rdata_o (b_rent)
  );

  state_e           state_q, state_d;
  logic [AddrW-1:0] a_q, a_d;
  logic [TimeW-1:0] now_q, now_d;
  logic             slot_q, slot_d;
  logic [CCW-1:0]   ccnt_q, ccnt_d, crj_q, crj_d, cwj_q, cwj_d, mcnt_q, mcnt_d;
  logic [CIW-1:0]   chead_q, chead_d;
  logic [BCW-1:0]   bcnt_q, bcnt_d, lcnt_q, lcnt_d, brj_q, brj_d, bwj_q, bwj_d;
  logic [BIW-1:0]   bhead_q, bhead_d, lhead_q, lhead_d, bidx_q, bidx_d, lpos_q, lpos_d;
  logic             rv_q, rv_d;
  logic             bfound_q, bfound_d, lfound_q, lfound_d, lkept_q, lkept_d;
  logic             dela_q, dela_d, fseen_q, fseen_d, fmatch_q, fmatch_d;
  logic [TimeW-1:0] bstart_q, bstart_d, nm_q, nm_d;
  logic [LenW-1:0]  lms_q, lms_d, newlen_q, newlen_d;
  logic [1:0]       res_verd_q, res_verd_d;
  logic [LenW-1:0]  res_len_q, res_len_d;
  logic             m_valid_q, m_valid_d;
  logic [39:0]      m_data_q, m_data_d;

  // Scratch values of the combinational block.
  logic [BCW-1:0]   bprev;
  logic [CCW-1:0]   mtot;
  logic [LenW-1:0]  blen;
  logic             keep, full, push;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  always_comb begin
    state_d    = state_q;
    a_d        = a_q;
    now_d      = now_q;
    slot_d     = slot_q;
    ccnt_d     = ccnt_q;
    crj_d      = crj_q;
    cwj_d      = cwj_q;
    mcnt_d     = mcnt_q;
    chead_d    = chead_q;
    bcnt_d     = bcnt_q;
    lcnt_d     = lcnt_q;
    brj_d      = brj_q;
    bwj_d      = bwj_q;
    bhead_d    = bhead_q;
    lhead_d    = lhead_q;
    bidx_d     = bidx_q;
    lpos_d     = lpos_q;
    rv_d       = 1'b0;
    bfound_d   = bfound_q;
    lfound_d   = lfound_q;
    lkept_d    = lkept_q;
    dela_d     = dela_q;
    fseen_d    = fseen_q;
    fmatch_d   = fmatch_q;
    bstart_d   = bstart_q;
    nm_d       = nm_q;
    lms_d      = lms_q;
    newlen_d   = newlen_q;
    res_verd_d = res_verd_q;
    res_len_d  = res_len_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_data_d   = m_data_q;

    c_we    = 1'b0;
    c_waddr = cphys(chead_q, cwj_q[CIW-1:0]);
    c_wdata = c_rent;
    c_raddr = cphys(chead_q, crj_q[CIW-1:0]);
    b_we    = 1'b0;
    b_waddr = {1'b0, bphys(bhead_q, bwj_q[BIW-1:0])};
    b_wdata = b_rent;
    b_raddr = {1'b0, bphys(bhead_q, brj_q[BIW-1:0])};

    bprev = brj_q - BCW'(1);
    mtot  = '0;
    blen  = lfound_q ? lms_q : cfg.initial_ban_ms;
    keep  = 1'b0;
    full  = 1'b0;
    push  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          a_d      = s_axis_tdata[AddrW-1:0];
          now_d    = s_axis_tdata[AddrW +: TimeW];
          slot_d   = s_axis_tuser[0];
          bfound_d = 1'b0;
          lfound_d = 1'b0;
          lkept_d  = 1'b0;
          mcnt_d   = '0;
          fseen_d  = 1'b0;
          fmatch_d = 1'b0;
          brj_d    = '0;
          bwj_d    = '0;
          crj_d    = '0;
          cwj_d    = '0;
          state_d  = ST_BSCAN;
        end
      end

      ST_BSCAN: begin
        if (brj_q < bcnt_q) begin
          brj_d = brj_q + BCW'(1);
          rv_d  = 1'b1;
        end
        if (rv_q && b_rent.addr == a_q) begin
          bfound_d = 1'b1;
          bidx_d   = bprev[BIW-1:0];
          bstart_d = b_rent.tm;
        end
        if (brj_q == bcnt_q && !rv_q) begin
          brj_d   = '0;
          state_d = ST_LSCAN;
        end
      end

      ST_LSCAN: begin
        b_raddr = LenBase + {1'b0, bphys(lhead_q, brj_q[BIW-1:0])};
        if (brj_q < lcnt_q) begin
          brj_d = brj_q + BCW'(1);
          rv_d  = 1'b1;
        end
        if (rv_q && b_rent.addr == a_q) begin
          lfound_d = 1'b1;
          lms_d    = b_rent.ms;
        end
        if (brj_q == lcnt_q && !rv_q) begin
          brj_d   = '0;
          state_d = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        if (bfound_q && age_of(now_q, bstart_q) < TimeW'(blen)) begin
          res_verd_d = VERD_REJECT;
          res_len_d  = '0;
          state_d    = ST_DONE;
        end else begin
          // An expired ban takes the address's logged connections with it.
          dela_d  = bfound_q;
          nm_d    = sat_add(now_q, cfg.ban_memory_ms);
          state_d = ST_BCOMP;
        end
      end

      ST_BCOMP: begin
        if (brj_q < bcnt_q) begin
          brj_d = brj_q + BCW'(1);
          rv_d  = 1'b1;
        end
        if (rv_q) begin
          keep = !(dela_q && bprev[BIW-1:0] == bidx_q);
          if (keep) begin
            b_we  = 1'b1;
            bwj_d = bwj_q + BCW'(1);
          end
        end
        if (brj_q == bcnt_q && !rv_q) begin
          bcnt_d  = bwj_q;
          brj_d   = '0;
          bwj_d   = '0;
          state_d = ST_LCOMP;
        end
      end

      ST_LCOMP: begin
        b_raddr = LenBase + {1'b0, bphys(lhead_q, brj_q[BIW-1:0])};
        b_waddr = LenBase + {1'b0, bphys(lhead_q, bwj_q[BIW-1:0])};
        if (brj_q < lcnt_q) begin
          brj_d = brj_q + BCW'(1);
          rv_d  = 1'b1;
        end
        if (rv_q) begin
          keep = !(b_rent.tm < now_q);
          if (keep) begin
            b_we  = 1'b1;
            bwj_d = bwj_q + BCW'(1);
            if (b_rent.addr == a_q) begin
              lkept_d = 1'b1;
              lpos_d  = bphys(lhead_q, bwj_q[BIW-1:0]);
            end
          end
        end
        if (brj_q == lcnt_q && !rv_q) begin
          lcnt_d  = bwj_q;
          brj_d   = '0;
          bwj_d   = '0;
          state_d = ST_CCOMP;
        end
      end

      ST_CCOMP: begin
        if (crj_q < ccnt_q) begin
          crj_d = crj_q + CCW'(1);
          rv_d  = 1'b1;
        end
        if (rv_q) begin
          keep = !(dela_q && c_rent.addr == a_q) &&
                 (age_of(now_q, c_rent.tm) < TimeW'(cfg.window_ms));
          if (keep) begin
            c_we  = 1'b1;
            cwj_d = cwj_q + CCW'(1);
            if (c_rent.addr == a_q) mcnt_d = mcnt_q + CCW'(1);
            if (!fseen_q) begin
              fseen_d  = 1'b1;
              fmatch_d = (c_rent.addr == a_q);
            end
          end
        end
        if (crj_q == ccnt_q && !rv_q) begin
          ccnt_d  = cwj_q;
          crj_d   = '0;
          cwj_d   = '0;
          state_d = ST_CPUSH;
        end
      end

      ST_CPUSH: begin
        // A zero window forgets the new attempt at once, so nothing is logged.
        push    = (cfg.window_ms != '0);
        full    = (ccnt_q == CFull);
        c_wdata = '{addr: a_q, tm: now_q};
        mtot    = mcnt_q;
        if (push) begin
          c_we = 1'b1;
          if (full) begin
            // The oldest slot is reused and the head moves past it.
            c_waddr = chead_q;
            chead_d = (chead_q == CIW'(CONN_DEPTH - 1)) ? '0 : chead_q + CIW'(1);
            mtot    = mcnt_q - CCW'(fmatch_q) + CCW'(1);
          end else begin
            c_waddr = cphys(chead_q, ccnt_q[CIW-1:0]);
            ccnt_d  = ccnt_q + CCW'(1);
            mtot    = mcnt_q + CCW'(1);
          end
        end
        // The new attempt has age zero, so the recency test always holds here.
        if (push && MW'(mtot) > MW'(cfg.burst_limit)) begin
          newlen_d = !lkept_q ? cfg.initial_ban_ms :
                     (lms_q[LenW-1] ? '1 : {lms_q[LenW-2:0], 1'b0});
          state_d  = ST_BPUSH;
        end else begin
          res_verd_d = slot_q ? VERD_ACCEPT : VERD_FULL;
          res_len_d  = '0;
          state_d    = ST_DONE;
        end
      end

      ST_BPUSH: begin
        b_we    = 1'b1;
        b_wdata = '{addr: a_q, ms: '0, tm: now_q};
        if (bcnt_q == BFull) begin
          b_waddr = {1'b0, bhead_q};
          bhead_d = (bhead_q == BIW'(BAN_DEPTH - 1)) ? '0 : bhead_q + BIW'(1);
        end else begin
          b_waddr = {1'b0, bphys(bhead_q, bcnt_q[BIW-1:0])};
          bcnt_d  = bcnt_q + BCW'(1);
        end
        state_d = ST_LUPD;
      end

      ST_LUPD: begin
        b_we = 1'b1;
        if (lkept_q) begin
          b_waddr = LenBase + {1'b0, lpos_q};
          b_wdata = '{addr: a_q, ms: newlen_q, tm: sat_add(nm_q, newlen_q)};
        end else begin
          b_wdata = '{addr: a_q, ms: newlen_q, tm: nm_q};
          if (lcnt_q == BFull) begin
            b_waddr = LenBase + {1'b0, lhead_q};
            lhead_d = (lhead_q == BIW'(BAN_DEPTH - 1)) ? '0 : lhead_q + BIW'(1);
          end else begin
            b_waddr = LenBase + {1'b0, bphys(lhead_q, lcnt_q[BIW-1:0])};
            lcnt_d  = lcnt_q + BCW'(1);
          end
        end
        res_verd_d = VERD_BANNED;
        res_len_d  = newlen_q;
        state_d    = ST_DONE;
      end

      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {6'b0, res_len_q, res_verd_q};
          state_d   = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ccnt_q    <= '0;
      crj_q     <= '0;
      cwj_q     <= '0;
      chead_q   <= '0;
      bcnt_q    <= '0;
      lcnt_q    <= '0;
      brj_q     <= '0;
      bwj_q     <= '0;
      bhead_q   <= '0;
      lhead_q   <= '0;
      rv_q      <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ccnt_q    <= ccnt_d;
      crj_q     <= crj_d;
      cwj_q     <= cwj_d;
      chead_q   <= chead_d;
      bcnt_q    <= bcnt_d;
      lcnt_q    <= lcnt_d;
      brj_q     <= brj_d;
      bwj_q     <= bwj_d;
      bhead_q   <= bhead_d;
      lhead_q   <= lhead_d;
      rv_q      <= rv_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    now_q      <= now_d;
    slot_q     <= slot_d;
    mcnt_q     <= mcnt_d;
    bidx_q     <= bidx_d;
    lpos_q     <= lpos_d;
    bfound_q   <= bfound_d;
    lfound_q   <= lfound_d;
    lkept_q    <= lkept_d;
    dela_q     <= dela_d;
    fseen_q    <= fseen_d;
    fmatch_q   <= fmatch_d;
    bstart_q   <= bstart_d;
    nm_q       <= nm_d;
    lms_q      <= lms_d;
    newlen_q   <= newlen_d;
    res_verd_q <= res_verd_d;
    res_len_q  <= res_len_d;
    m_data_q   <= m_data_d;
  end

endmodule

// ===== design/cfb_ram.sv =====
// ----------------------------------------------------------------------------
// cfb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cfb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/cfb_cfg.sv =====
// ----------------------------------------------------------------------------
// cfb_cfg
// Configuration register file with its write channel.
// ----------------------------------------------------------------------------
module cfb_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cfb_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [cfb_pkg::CfgDataW-1:0]   cfg_data_i,
  output cfb_pkg::cfg_t                  cfg_o
);
  import cfb_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_WINDOW_MS:      cfg_d.window_ms      = cfg_data_i[WindowW-1:0];
        CFG_BURST_LIMIT:    cfg_d.burst_limit    = cfg_data_i[BurstW-1:0];
        CFG_RECENT_MS:      cfg_d.recent_ms      = cfg_data_i[WindowW-1:0];
        CFG_INITIAL_BAN_MS: cfg_d.initial_ban_ms = cfg_data_i[LenW-1:0];
        CFG_BAN_MEMORY_MS:  cfg_d.ban_memory_ms  = cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{window_ms: WindowReset, burst_limit: BurstReset, recent_ms: RecentReset,
                 initial_ban_ms: InitialReset, ban_memory_ms: MemoryReset};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the connection flood ban table. An in-bench
// predictor keeps its own copy of the connection log, the ban list and the
// ban length records. It works out each verdict as the attempt is accepted,
// and a scoreboard compares every verdict item that the block returns. Bursts
// from a small pool of addresses drive bans, repeat bans and ban expiry under
// several register settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import cfb_pkg::*;

  localparam int ConnDepth = 64;
  localparam int BanDepth  = 16;
  localparam logic [TimeW-1:0] TimeMax = '1;
  localparam longint CycleLimit = 3000000;

  typedef struct {
    logic [AddrW-1:0] addr;
    logic [TimeW-1:0] stamp;
  } conn_rec_t;

  typedef struct {
    logic [AddrW-1:0] addr;
    logic [LenW-1:0]  len;
    logic [TimeW-1:0] expiry;
  } len_rec_t;

  typedef struct {
    verdict_e         verdict;
    logic [LenW-1:0]  len;
  } verdict_t;

  class ban_scoreboard;
    cfg_t      cfg;
    conn_rec_t conn_log[$];
    conn_rec_t ban_list[$];
    len_rec_t  len_recs[$];
    verdict_t  expected_q[$];
    int        errors;

    function new();
      cfg.window_ms      = WindowReset;
      cfg.burst_limit    = BurstReset;
      cfg.recent_ms      = RecentReset;
      cfg.initial_ban_ms = InitialReset;
      cfg.ban_memory_ms  = MemoryReset;
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] val);
      case (idx)
        CFG_WINDOW_MS:      cfg.window_ms = val[WindowW-1:0];
        CFG_BURST_LIMIT:    cfg.burst_limit = val[BurstW-1:0];
        CFG_RECENT_MS:      cfg.recent_ms = val[WindowW-1:0];
        CFG_INITIAL_BAN_MS: cfg.initial_ban_ms = val;
        CFG_BAN_MEMORY_MS:  cfg.ban_memory_ms = val;
        default: ;
      endcase
    endfunction

    function longint unsigned age(logic [TimeW-1:0] now, logic [TimeW-1:0] t);
      return (now >= t) ? longint'(now - t) : 0;
    endfunction

    function longint unsigned sat_add(longint unsigned a, longint unsigned b);
      longint unsigned s;
      s = a + b;
      return (s > longint'(TimeMax)) ? longint'(TimeMax) : s;
    endfunction

    function int find_len(logic [AddrW-1:0] a);
      foreach (len_recs[i]) if (len_recs[i].addr == a) return i;
      return -1;
    endfunction

    function void prune_log(logic [TimeW-1:0] now);
      for (int i = conn_log.size() - 1; i >= 0; i--)
        if (age(now, conn_log[i].stamp) >= cfg.window_ms) conn_log.delete(i);
    endfunction

    function verdict_t decide(logic [AddrW-1:0] a, logic [TimeW-1:0] now, bit slot);
      verdict_t r;
      longint unsigned blen, lowest, newlen;
      int count, li;
      conn_rec_t c;
      len_rec_t lr;
      r.verdict = VERD_ACCEPT;
      r.len = '0;
      // Newest ban first; an expired ban also wipes the address's history.
      for (int x = ban_list.size() - 1; x >= 0; x--) begin
        if (ban_list[x].addr != a) continue;
        li = find_len(a);
        blen = (li >= 0) ? len_recs[li].len : cfg.initial_ban_ms;
        if (age(now, ban_list[x].stamp) >= blen) begin
          for (int i = conn_log.size() - 1; i >= 0; i--)
            if (conn_log[i].addr == a) conn_log.delete(i);
          ban_list.delete(x);
          continue;
        end
        r.verdict = VERD_REJECT;
        return r;
      end
      for (int x = len_recs.size() - 1; x >= 0; x--)
        if (len_recs[x].expiry < now) len_recs.delete(x);
      prune_log(now);
      if (conn_log.size() >= ConnDepth) conn_log.delete(0);
      c.addr = a;
      c.stamp = now;
      conn_log = {conn_log, c};
      prune_log(now);
      lowest = cfg.window_ms;
      count = 0;
      foreach (conn_log[i]) begin
        if (conn_log[i].addr != a) continue;
        count++;
        if (age(now, conn_log[i].stamp) < lowest) lowest = age(now, conn_log[i].stamp);
      end
      if (count > cfg.burst_limit && lowest <= cfg.recent_ms) begin
        if (ban_list.size() >= BanDepth) ban_list.delete(0);
        c.addr = a;
        c.stamp = now;
        ban_list = {ban_list, c};
        li = find_len(a);
        if (li < 0) begin
          newlen = cfg.initial_ban_ms;
          if (len_recs.size() >= BanDepth) len_recs.delete(0);
          lr.addr = a;
          lr.len = LenW'(newlen);
          lr.expiry = TimeW'(sat_add(now, cfg.ban_memory_ms));
          len_recs = {len_recs, lr};
        end else begin
          newlen = longint'(len_recs[li].len) * 2;
          if (newlen > 64'hFFFF_FFFF) newlen = 64'hFFFF_FFFF;
          len_recs[li].len = LenW'(newlen);
          len_recs[li].expiry = TimeW'(sat_add(sat_add(now, cfg.ban_memory_ms), newlen));
        end
        r.verdict = VERD_BANNED;
        r.len = LenW'(newlen);
        return r;
      end
      r.verdict = slot ? VERD_ACCEPT : VERD_FULL;
      return r;
    endfunction

    function void note_attempt(logic [AddrW-1:0] a, logic [TimeW-1:0] now, bit slot);
      expected_q = {expected_q, decide(a, now, slot)};
    endfunction

    function void check_verdict(logic [39:0] data);
      verdict_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected verdict item, actual %h", $time, data);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (data[1:0] != e.verdict) begin
        $display("%0t: verdict mismatch, expected %0d, actual %0d", $time, e.verdict,
                 data[1:0]);
        errors++;
      end
      if (data[33:2] != e.len) begin
        $display("%0t: ban length mismatch, expected %0d, actual %0d", $time, e.len,
                 data[33:2]);
        errors++;
      end
      if (data[39:34] != '0) begin
        $display("%0t: fill bits mismatch, expected 0, actual %h", $time, data[39:34]);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic [71:0]       s_axis_tdata;
  logic [0:0]        s_axis_tuser;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [39:0]       m_axis_tdata;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  cfg_reg_e          cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  ban_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int attempts_sent;
  logic [TimeW-1:0] clock_ms;
  logic [AddrW-1:0] addr_pool[24];
  int pool_size;
  longint unsigned step_ms;

  connection_flood_ban_table #(
    .CONN_DEPTH(ConnDepth),
    .BAN_DEPTH (BanDepth)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    longint cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("connection_flood_ban_table test failed");
        $finish;
      end
    end
  end

  // Verdict receiver with random stalls and one long hold-off that fills the block.
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && attempts_sent >= 700) begin
        held = 1'b1;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_verdict(m_axis_tdata);
  end

  task automatic send_attempt(logic [AddrW-1:0] a, logic [TimeW-1:0] now, bit slot);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {now, a};
    s_axis_tuser  <= slot;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_attempt(a, now, slot);
    attempts_sent++;
  endtask

  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (160) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic apply_setting(logic [CfgDataW-1:0] win, logic [CfgDataW-1:0] burst,
                               logic [CfgDataW-1:0] recent, logic [CfgDataW-1:0] init,
                               logic [CfgDataW-1:0] mem);
    settle();
    write_reg(CFG_WINDOW_MS, win);
    write_reg(CFG_BURST_LIMIT, burst);
    write_reg(CFG_RECENT_MS, recent);
    write_reg(CFG_INITIAL_BAN_MS, init);
    write_reg(CFG_BAN_MEMORY_MS, mem);
  endtask

  function automatic logic [TimeW-1:0] next_time();
    int pick;
    pick = $urandom_range(199);
    if (pick == 0) return TimeW'({$urandom(), $urandom()});
    if (pick == 1) return (clock_ms > 50) ? clock_ms - $urandom_range(50) : 0;
    if (pick == 2) return TimeMax - $urandom_range(3);
    if (clock_ms > TimeMax - step_ms) return TimeMax;
    return clock_ms + $urandom_range(int'(step_ms));
  endfunction

  // Mostly bursts from one pooled address, the rest scattered single attempts.
  task automatic run_random(int count, int burst_max);
    int done, len;
    logic [AddrW-1:0] a;
    done = 0;
    while (done < count) begin
      if ($urandom_range(99) < 65) begin
        a = addr_pool[$urandom_range(pool_size - 1)];
        len = $urandom_range(1, burst_max);
      end else begin
        a = ($urandom_range(3) == 0) ? $urandom() : addr_pool[$urandom_range(pool_size - 1)];
        len = 1;
      end
      repeat (len) begin
        if (done >= count) break;
        clock_ms = next_time();
        send_attempt(a, clock_ms, $urandom_range(9) != 0);
        done++;
      end
    end
  endtask

  task automatic set_idling(int phase_item);
    if (phase_item < 650) begin
      send_idle_pct = 28;
      recv_idle_pct = 78;
    end else if (phase_item < 1300) begin
      send_idle_pct = 78;
      recv_idle_pct = 28;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_WINDOW_MS;
    cfg_data_i = '0;
    attempts_sent = 0;
    send_idle_pct = 28;
    recv_idle_pct = 78;
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (int i = 2; i < 24; i++) addr_pool[i] = $urandom();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes, first ban, rejection, expiry and a repeat ban.
    send_attempt(32'h0, 40'h0, 1'b1);
    send_attempt(32'hFFFF_FFFF, 40'h0, 1'b0);
    for (int i = 0; i < 5; i++) send_attempt(32'h0A00_0001, 40'd100 + i, 1'b1);
    send_attempt(32'h0A00_0001, 40'd200, 1'b1);
    send_attempt(32'h0A00_0001, 40'd10104, 1'b1);
    for (int i = 0; i < 5; i++) send_attempt(32'h0A00_0001, 40'd10200 + i, 1'b0);
    send_attempt(32'h0A00_0001, 40'd20000, 1'b1);
    send_attempt(32'h5555_AAAA, TimeMax, 1'b0);
    send_attempt(32'hAAAA_5555, 40'd50, 1'b1);
    send_attempt(32'h0A00_0001, TimeMax, 1'b1);
    clock_ms = TimeMax;

    // Five settings, the extremes among them, each with about 390 attempts.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          apply_setting(30000, 4, 10000, 10000, 300000);
          step_ms = 600;
          pool_size = 6;
        end
        1: begin
          apply_setting(1000000, 63, 1000000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
          step_ms = 20;
          pool_size = 3;
        end
        2: begin
          apply_setting(1, 1, 0, 1, 0);
          step_ms = 1;
          pool_size = 24;
        end
        3: begin
          apply_setting(5000, 2, 2000, 3, 100000);
          step_ms = 150;
          pool_size = 24;
        end
        default: begin
          apply_setting(20000, 3, 20000, 32'hC000_0000, 32'hFFFF_FFFF);
          step_ms = 400;
          pool_size = 8;
        end
      endcase
      clock_ms = $urandom_range(1000);
      for (int blk = 0; blk < 3; blk++) begin
        set_idling(phase * 390 + blk * 130);
        run_random(130, (phase == 1) ? 70 : 8);
      end
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0) $display("connection_flood_ban_table test passed");
    else $display("connection_flood_ban_table test failed");
    $finish;
  end

endmodule

// ===== files.f =====
design/cfb_pkg.sv
design/cfb_ram.sv
design/cfb_cfg.sv
design/connection_flood_ban_table.sv
verif/testbench.sv
